/* rtl/core/mccd_pkg.sv */
// Shared types and constants for the minimum-coin change solver.
package mccd_pkg;

    localparam int CMD_W      = 2;
    localparam int COIN_W     = 10;
    localparam int AMT_W      = 10;
    localparam int CNT_W      = 10;
    localparam int ENTRY_W    = CNT_W + 1;
    localparam int IN_TDATA_W = 24;
    localparam int IN_TUSER_W = 2;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;    // input transfer this cycle
        logic init;    // seed table entry zero, restart amount at one
        logic scan;    // fetch coin k, advance k
        logic write;   // store the current amount's entry, advance amount
        logic result;  // load the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic coins_empty;
        logic last_coin;
        logic at_target;
        logic target_zero;
        logic target_oob;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/core/min_coin_change_dp_core.sv */
// Top level of the minimum-coin change solver: sequencer plus datapath.
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: command[1:0]; tdata: coin_value[9:0], target_amount[19:10]
// m_axis    out  tdata: found[0], fewest[10:1], list_overflowed[11]
//
// A solve for amount A fills the table for amounts one to A: per amount, it fetches
// each stored coin and reads the table, drains the read pipeline and writes the entry
// (only the write with an empty list); it then reads entry A and loads the output register.
// Reset is synchronous, active low; coin list and table need no clearing.
// Input is taken only while the sequencer is idle; a result still waiting in the
// output register holds the next finished solve, and with it the input.
module min_coin_change_dp_core #(
    parameter int MAX_COINS  = 16,
    parameter int MAX_AMOUNT = 1023
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [mccd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // coin_value, target_amount
    input  logic [mccd_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,  // command
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mccd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata   // found, fewest, list_overflowed
);

    mccd_pkg::t_dp_cmd cmd;
    mccd_pkg::t_dp_sts sts;

    mccd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (cmd),
        .i_sts           (sts)
    );

    mccd_dpath #(
        .MAX_COINS  (MAX_COINS),
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

/* rtl/core/mccd_ctrl.sv */
// Sequencer for the minimum-coin change solver.
module mccd_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic [mccd_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                                o_s_axis_tready,
    output mccd_pkg::t_dp_cmd                   o_cmd,
    input  mccd_pkg::t_dp_sts                   i_sts
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START  = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_FLUSH  = 7'b0001000,
        S_WRITE  = 7'b0010000,
        S_FETCH  = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.load   = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_s_axis_tuser == mccd_pkg::CMD_SOLVE) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.init = 1'b1;
                priority if (i_sts.target_oob) begin
                    n_state = S_RESULT;
                end else if (i_sts.target_zero) begin
                    n_state = S_FETCH;
                end else if (i_sts.coins_empty) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last_coin) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                priority if (i_sts.at_target) begin
                    n_state = S_FETCH;
                end else if (i_sts.coins_empty) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FETCH: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/mccd_dpath.sv */
// Coin list, DP table memory, minimum search and output register.
module mccd_dpath #(
    parameter int MAX_COINS  = 16,
    parameter int MAX_AMOUNT = 1023
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mccd_pkg::t_dp_cmd                   i_cmd,
    output mccd_pkg::t_dp_sts                   o_sts,
    input  logic [mccd_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    input  logic [mccd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mccd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int COIN_W    = mccd_pkg::COIN_W;
    localparam int AMT_W     = mccd_pkg::AMT_W;
    localparam int CNT_W     = mccd_pkg::CNT_W;
    localparam int ENTRY_W   = mccd_pkg::ENTRY_W;
    localparam int TBL_LAST  = (MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023;
    localparam int TBL_DEPTH = TBL_LAST + 1;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int KW        = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CW        = $clog2(MAX_COINS + 1);

    // coin list
    logic [COIN_W-1:0]  r_coin_mem [MAX_COINS];
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic [AMT_W-1:0]   r_target;

    // sequencing counters
    logic [KW-1:0]      r_k;
    logic [AW-1:0]      r_amt;

    // pipeline: coin fetch, table read, fold
    logic               r_cvld;
    logic [COIN_W-1:0]  r_coin;
    logic               r_rd_vld;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] r_dp_mem [TBL_DEPTH];

    logic               r_have;
    logic [CNT_W-1:0]   r_best;
    logic               n_have;
    logic [CNT_W-1:0]   n_best;

    logic               r_out_vld;
    logic               r_found;
    logic [CNT_W-1:0]   r_min;
    logic               r_out_ovf;

    logic [mccd_pkg::CMD_W-1:0] in_cmd;
    logic [COIN_W-1:0]  in_coin;
    logic [AMT_W-1:0]   in_amt;
    logic               coin_use;
    logic [AW-1:0]      rd_addr;
    logic [CNT_W-1:0]   cand;
    logic               take;
    logic               target_oob;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    assign in_cmd  = i_s_axis_tuser[mccd_pkg::CMD_W-1:0];
    assign in_coin = i_s_axis_tdata[COIN_W-1:0];
    assign in_amt  = i_s_axis_tdata[COIN_W +: AMT_W];

    assign target_oob = {22'd0, r_target} > 32'(MAX_AMOUNT);

    assign o_sts.coins_empty = (r_count == '0);
    assign o_sts.last_coin   = ((CW'(r_k) + CW'(1)) == r_count);
    assign o_sts.at_target   = (AMT_W'(r_amt) == r_target);
    assign o_sts.target_zero = (r_target == '0);
    assign o_sts.target_oob  = target_oob;
    assign o_sts.out_free    = ~r_out_vld | i_m_axis_tready;

    // coin list updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (in_cmd == mccd_pkg::CMD_CLEAR) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (in_cmd == mccd_pkg::CMD_ADD) begin
                if (r_count == CW'(MAX_COINS)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_cmd == mccd_pkg::CMD_ADD && r_count != CW'(MAX_COINS)) begin
            r_coin_mem[r_count[KW-1:0]] <= in_coin;
        end
        if (i_cmd.load && in_cmd == mccd_pkg::CMD_SOLVE) begin
            r_target <= in_amt;
        end
        r_coin <= r_coin_mem[r_k];
    end

    // amount and coin counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= '0;
            r_amt <= '0;
        end else if (i_cmd.init) begin
            r_k   <= '0;
            r_amt <= AW'(1);
        end else if (i_cmd.write) begin
            r_k   <= '0;
            r_amt <= r_amt + AW'(1);
        end else if (i_cmd.scan) begin
            r_k   <= r_k + KW'(1);
        end
    end

    // table read address: current amount less the fetched coin, else the target
    assign coin_use = r_cvld && (r_coin != '0) && (r_coin <= COIN_W'(r_amt));
    assign rd_addr  = r_cvld ? AW'(COIN_W'(r_amt) - r_coin) : AW'(r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_cvld   <= i_cmd.scan;
            r_rd_vld <= coin_use;
        end
    end

    // fold the returned entry into the running minimum
    assign cand = r_rd_data[CNT_W-1:0] + CNT_W'(1);
    assign take = r_rd_vld && r_rd_data[CNT_W] && (!r_have || cand < r_best);

    always_comb begin
        n_have = r_have;
        n_best = r_best;
        if (take) begin
            n_have = 1'b1;
            n_best = cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.init || i_cmd.write) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
        r_best <= n_best;
    end

    assign wr_en   = i_cmd.init | i_cmd.write;
    assign wr_addr = i_cmd.init ? '0 : r_amt;
    assign wr_data = i_cmd.init ? {1'b1, {CNT_W{1'b0}}}
                               : {n_have, (n_have ? n_best : {CNT_W{1'b0}})};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_dp_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_dp_mem[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.result) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_found   <= ~target_oob & r_rd_data[CNT_W];
            r_min     <= (~target_oob & r_rd_data[CNT_W]) ? r_rd_data[CNT_W-1:0] : '0;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'd0, r_out_ovf, r_min, r_found};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_COINS))
        else $error("coin count beyond list size");

    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> r_amt != '0)
        else $error("table entry zero overwritten by a search");

    a_scan_has_coins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> r_count != '0)
        else $error("coin scan with empty list");

    a_nonzero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.result && !target_oob && r_rd_data[CNT_W] && r_target != '0)
        |-> r_rd_data[CNT_W-1:0] != '0)
        else $error("positive amount reached with zero coins");
`endif

endmodule

/* bench/tb_min_coin_change_dp_core.sv */
// Self-checking bench for the minimum-coin change solver: directed corners, then random runs.
`timescale 1ns / 100ps

module tb_min_coin_change_dp_core;

    localparam int COIN_SLOTS  = 16;
    localparam int TOP_AMOUNT  = 1023;
    localparam int QUIET_LIMIT = 100000;

    // Spare command code: the block must ignore it
    localparam logic [mccd_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic                       found;
        logic [mccd_pkg::CNT_W-1:0] fewest;
        logic                       dropped;
    } t_change_answer;

    class t_change_tracker;
        logic [mccd_pkg::COIN_W-1:0] coins[$];
        logic                        dropped;
        t_change_answer              pending_answers[$];
        int                          errors;

        function new();
            dropped = 1'b0;
            errors  = 0;
        endfunction

        // Bottom-up table, same order of trial as the hardware
        function t_change_answer fewest_coins(logic [mccd_pkg::AMT_W-1:0] amount);
            logic                       reach [0:TOP_AMOUNT];
            logic [mccd_pkg::CNT_W-1:0] tally [0:TOP_AMOUNT];
            logic [mccd_pkg::CNT_W:0]   best;
            logic [mccd_pkg::CNT_W:0]   cand;
            logic                       have;
            t_change_answer             ans;
            reach[0] = 1'b1;
            tally[0] = '0;
            for (int i = 1; i <= int'(amount); i++) begin
                have = 1'b0;
                best = '0;
                foreach (coins[k]) begin
                    if (coins[k] != 0 && int'(coins[k]) <= i && reach[i - int'(coins[k])]) begin
                        cand = {1'b0, tally[i - int'(coins[k])]} + 1'b1;
                        if (!have || cand < best) begin
                            best = cand;
                            have = 1'b1;
                        end
                    end
                end
                reach[i] = have;
                tally[i] = have ? best[mccd_pkg::CNT_W-1:0] : '0;
            end
            ans.found   = reach[amount];
            ans.fewest  = reach[amount] ? tally[amount] : '0;
            ans.dropped = dropped;
            return ans;
        endfunction

        function void note_item(logic [mccd_pkg::CMD_W-1:0] cmd,
                                logic [mccd_pkg::COIN_W-1:0] coin,
                                logic [mccd_pkg::AMT_W-1:0] amount);
            case (cmd)
                mccd_pkg::CMD_CLEAR: begin
                    coins.delete();
                    dropped = 1'b0;
                end
                mccd_pkg::CMD_ADD: begin
                    if (coins.size() >= COIN_SLOTS) dropped = 1'b1;
                    else coins.push_back(coin);
                end
                mccd_pkg::CMD_SOLVE: begin
                    pending_answers.push_back(fewest_coins(amount));
                end
                default: ;
            endcase
        endfunction

        function void check_answer(logic [mccd_pkg::OUT_TDATA_W-1:0] word);
            t_change_answer got;
            t_change_answer want;
            got.found   = word[0];
            got.fewest  = word[10:1];
            got.dropped = word[11];
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.fewest !== want.fewest) begin
                $display("%0t: fewest expected %0d actual %0d",
                         $time, want.fewest, got.fewest);
                errors++;
            end
            if (got.dropped !== want.dropped) begin
                $display("%0t: list_overflowed expected %0d actual %0d",
                         $time, want.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [mccd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // coin_value, target_amount
    logic [mccd_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser = '0;   // command
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [mccd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;        // found, fewest, list_overflowed

    t_change_tracker tracker;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              counted;
    int              r_quiet_cycles;

    min_coin_change_dp_core #(
        .MAX_COINS  (COIN_SLOTS),
        .MAX_AMOUNT (TOP_AMOUNT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, checking and the no-progress watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            r_quiet_cycles  <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) tracker.check_answer(o_m_axis_tdata);
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready)) begin
                r_quiet_cycles <= 0;
            end else if (r_quiet_cycles >= QUIET_LIMIT) begin
                $display("min_coin_change_dp_core test failed");
                $finish;
            end else begin
                r_quiet_cycles <= r_quiet_cycles + 1;
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [mccd_pkg::CMD_W-1:0] cmd,
                             input logic [mccd_pkg::COIN_W-1:0] coin,
                             input logic [mccd_pkg::AMT_W-1:0] amount);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {{(mccd_pkg::IN_TDATA_W - mccd_pkg::COIN_W - mccd_pkg::AMT_W){1'b0}},
                            amount, coin};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tracker.note_item(cmd, coin, amount);
        if (cmd != CMD_SPARE) counted++;
    endtask

    // Hold the sender off until every outstanding answer has been taken
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_answers.size() != 0);
    endtask

    function automatic logic [mccd_pkg::COIN_W-1:0] pick_coin();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return mccd_pkg::COIN_W'($urandom_range(1, 12));
        if (roll < 75) return mccd_pkg::COIN_W'($urandom_range(13, 64));
        if (roll < 92) return mccd_pkg::COIN_W'($urandom_range(TOP_AMOUNT));
        return '0;
    endfunction

    // Keep most solves short: amounts up to 60, with one in twenty drawn over the full range
    function automatic logic [mccd_pkg::AMT_W-1:0] pick_amount();
        if ($urandom_range(19) == 0) return mccd_pkg::AMT_W'($urandom_range(TOP_AMOUNT));
        return mccd_pkg::AMT_W'($urandom_range(0, 60));
    endfunction

    task automatic run_random(input int quota);
        int goal;
        int n_add;
        goal = counted + quota;
        while (counted < goal) begin
            if ($urandom_range(99) < 12) begin
                send_item(mccd_pkg::CMD_W'($urandom_range(3)),
                          mccd_pkg::COIN_W'($urandom_range(TOP_AMOUNT)), pick_amount());
            end else begin
                if ($urandom_range(3) != 0)
                    send_item(mccd_pkg::CMD_CLEAR, mccd_pkg::COIN_W'($urandom_range(TOP_AMOUNT)),
                              mccd_pkg::AMT_W'($urandom_range(TOP_AMOUNT)));
                n_add = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
                repeat (n_add)
                    send_item(mccd_pkg::CMD_ADD, pick_coin(),
                              mccd_pkg::AMT_W'($urandom_range(TOP_AMOUNT)));
                repeat ($urandom_range(1, 3))
                    send_item(mccd_pkg::CMD_SOLVE, mccd_pkg::COIN_W'($urandom_range(TOP_AMOUNT)),
                              pick_amount());
            end
        end
    endtask

    initial begin
        tracker       = new();
        send_idle_pct = 36;
        recv_idle_pct = 58;
        counted       = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: zero target is reachable, anything else is not
        send_item(mccd_pkg::CMD_SOLVE, '0, '0);
        send_item(mccd_pkg::CMD_SOLVE, '0, 10'd5);
        send_item(CMD_SPARE, 10'd1023, 10'd1023);
        // Zero coin never helps; coin 1023 reaches the top amount alone but not amount two
        send_item(mccd_pkg::CMD_ADD, 10'd0, 10'd1023);
        send_item(mccd_pkg::CMD_ADD, 10'd1023, 10'd0);
        send_item(mccd_pkg::CMD_ADD, 10'd3, 10'd0);
        send_item(mccd_pkg::CMD_ADD, 10'd7, 10'd0);
        send_item(mccd_pkg::CMD_SOLVE, 10'd1023, 10'd1023);
        send_item(mccd_pkg::CMD_SOLVE, 10'd0, 10'd2);
        // Fill the list, then drop one coin
        for (int k = 0; k < 12; k++)
            send_item(mccd_pkg::CMD_ADD, mccd_pkg::COIN_W'(2 * k + 5), 10'd0);
        send_item(mccd_pkg::CMD_ADD, 10'd512, 10'd0);
        send_item(mccd_pkg::CMD_SOLVE, 10'd0, 10'd1023);
        // Clear resets the flag; unit coin gives the largest count
        send_item(mccd_pkg::CMD_CLEAR, 10'd1023, 10'd1023);
        send_item(mccd_pkg::CMD_ADD, 10'd1, 10'd0);
        send_item(mccd_pkg::CMD_SOLVE, 10'd0, 10'd1023);

        run_random(22);
        drain();
        send_idle_pct = 58;
        recv_idle_pct = 36;
        run_random(22);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(22);

        drain();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_answers.size() == 0) begin
            $display("min_coin_change_dp_core test passed");
        end else begin
            $display("min_coin_change_dp_core test failed");
        end
        $finish;
    end

endmodule
